// ===== design/kerl_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kerl_pkg
// Beat types and codes shared by the removal-by-rank list unit.
// ----------------------------------------------------------------------------
package kerl_pkg;

	typedef struct packed {
		logic [1:0]         mode;
		logic signed [31:0] load_value;
		logic [10:0]        rank;
	} item_t;

	typedef struct packed {
		logic signed [31:0] removed_value;
		logic [2:0]         status;
		logic [10:0]        remaining;
	} result_t;

	// mode codes; any code with the high bit set clears the list
	localparam logic [1:0] MODE_LOAD   = 2'd0;
	localparam logic [1:0] MODE_REMOVE = 2'd1;
	localparam logic [1:0] MODE_CLEAR  = 2'd2;

	localparam logic [2:0] ST_LOADED   = 3'd0;
	localparam logic [2:0] ST_REMOVED  = 3'd1;
	localparam logic [2:0] ST_BAD_RANK = 3'd2;
	localparam logic [2:0] ST_FULL     = 3'd3;
	localparam logic [2:0] ST_CLEARED  = 3'd4;

endpackage
`default_nettype wire

// ===== design/kerl_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kerl_ram
// Simple dual-port RAM: one synchronous write port, one registered read port.
// ----------------------------------------------------------------------------
module kerl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ===== design/kth_element_removal_list_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kth_element_removal_list_unit
// Insertion-ordered list with removal by rank. A count tree over the
// positions (stored in RAM) finds the k-th present entry by binary descent.
// ----------------------------------------------------------------------------
//  channel   signals                        beat
//  item      item_valid/item_ready/item     mode, load_value, rank
//  result    result_valid/result_ready/     removed_value, status, remaining
//            result
//
//  L = $clog2(CAPACITY+1) tree levels (11 at CAPACITY 1024).
//  Load: an update walk reads then writes each tree node it updates (at
//  most L). Remove: L descent levels, each in range reading a node then
//  comparing, then the update walk; bad rank, store full and clear go
//  straight to S_DONE. The tree RAM has a single read port.
//  Reset and clear zero just the fill and remaining counts; nodes whose span
//  starts past the fill count read as zero, so no clearing pass is needed.
//  A waiting result does not block acceptance; a finished item waits in its
//  last state until the result register is free.
// ----------------------------------------------------------------------------
module kth_element_removal_list_unit #(
	parameter int CAPACITY = 1024
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	output      logic              item_ready,
	input  wire kerl_pkg::item_t   item,
	output      logic              result_valid,
	input  wire logic              result_ready,
	output      kerl_pkg::result_t result
);

	import kerl_pkg::*;

	localparam int PW = $clog2(CAPACITY + 1);   // positions 0..CAPACITY
	localparam int AW = $clog2(CAPACITY);
	localparam int RW = (PW > 11) ? PW : 11;
	localparam logic [PW-1:0] TOP_STEP = PW'(1) << (PW - 1);
	localparam logic [PW:0]   CAP_W    = (PW + 1)'(CAPACITY);
	localparam logic [PW-1:0] CAP_P    = PW'(CAPACITY);

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_FIND_RD  = 3'd1;
	localparam logic [2:0] S_FIND_CMP = 3'd2;
	localparam logic [2:0] S_ADD_RD   = 3'd3;
	localparam logic [2:0] S_ADD_WR   = 3'd4;
	localparam logic [2:0] S_DONE     = 3'd5;

	logic [2:0]    state_q;
	logic [PW-1:0] pos_q;
	logic [PW-1:0] step_q;
	logic [PW-1:0] nxt_q;
	logic [PW-1:0] k_q;
	logic          up_q;
	logic [2:0]    status_q;
	logic [PW-1:0] loaded_q;
	logic [PW-1:0] remaining_q;
	logic [AW-1:0] val_addr_q;
	logic          out_valid_q;
	result_t       out_q;

	logic          accept;
	logic          is_clear;
	logic          is_load;
	logic          full;
	logic          rank_bad;
	logic [RW-1:0] rank_x;
	logic [RW-1:0] rem_x;

	logic [PW-1:0] lowbit;
	logic [PW-1:0] walk_b;
	logic [PW:0]   walk_sum;
	logic          walk_over;
	logic [PW-1:0] node;
	logic [PW-1:0] node_base;
	logic [PW-1:0] node_cnt;
	logic [PW-1:0] find_pos;
	logic [PW-1:0] find_k;

	logic          vs_we;
	logic [31:0]   vs_rdata;
	logic          tr_we;
	logic [AW-1:0] tr_raddr;
	logic [PW-1:0] tr_wdata;
	logic [PW-1:0] tr_rdata;
	logic          out_free;

	assign item_ready   = (state_q == S_IDLE);
	assign accept       = item_valid && item_ready;
	assign result_valid = out_valid_q;
	assign result       = out_q;
	assign out_free     = !out_valid_q || result_ready;

	assign is_clear = item.mode[1];
	assign is_load  = (item.mode == MODE_LOAD);
	assign full     = (loaded_q == CAP_P);
	assign rank_x   = RW'(item.rank);
	assign rem_x    = RW'(remaining_q);
	assign rank_bad = (item.rank == '0) || (rank_x > rem_x);

	// shared walk adder: descent step in the search, lowest set bit on update
	assign lowbit    = pos_q & (~pos_q + 1'b1);
	assign walk_b    = (state_q == S_FIND_RD) ? step_q : lowbit;
	assign walk_sum  = {1'b0, pos_q} + {1'b0, walk_b};
	assign walk_over = (walk_sum > CAP_W);

	// a node spans (node - lowbit, node]; spans starting past the fill are stale
	assign node      = (state_q == S_FIND_CMP) ? nxt_q : pos_q;
	assign node_base = node & (node - 1'b1);
	assign node_cnt  = (node_base < loaded_q) ? tr_rdata : '0;

	// search outcome of the current level
	always_comb begin
		find_pos = pos_q;
		find_k   = k_q;
		if (state_q == S_FIND_CMP && node_cnt < k_q) begin
			find_pos = nxt_q;
			find_k   = k_q - node_cnt;
		end
	end

	assign vs_we    = accept && is_load && !full;
	assign tr_we    = (state_q == S_ADD_WR);
	assign tr_wdata = up_q ? node_cnt + 1'b1 : node_cnt - 1'b1;
	assign tr_raddr = (state_q == S_FIND_RD) ? AW'(walk_sum - 1'b1) : AW'(pos_q - 1'b1);

	kerl_ram #(
		.WIDTH (32),
		.DEPTH (CAPACITY)
	) u_value_ram (
		.clk   (clk),
		.we    (vs_we),
		.waddr (AW'(loaded_q)),
		.wdata (item.load_value),
		.raddr (val_addr_q),
		.rdata (vs_rdata)
	);

	kerl_ram #(
		.WIDTH (PW),
		.DEPTH (CAPACITY)
	) u_tree_ram (
		.clk   (clk),
		.we    (tr_we),
		.waddr (AW'(pos_q - 1'b1)),
		.wdata (tr_wdata),
		.raddr (tr_raddr),
		.rdata (tr_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			loaded_q    <= '0;
			remaining_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// in S_DONE the result register is either held or reloaded below
			if (result_ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (is_clear) begin
							loaded_q    <= '0;
							remaining_q <= '0;
							status_q    <= ST_CLEARED;
							state_q     <= S_DONE;
						end else if (is_load) begin
							if (full) begin
								status_q <= ST_FULL;
								state_q  <= S_DONE;
							end else begin
								status_q <= ST_LOADED;
								pos_q    <= loaded_q + 1'b1;
								up_q     <= 1'b1;
								state_q  <= S_ADD_RD;
							end
						end else if (rank_bad) begin
							status_q <= ST_BAD_RANK;
							state_q  <= S_DONE;
						end else begin
							status_q <= ST_REMOVED;
							k_q      <= PW'(item.rank);
							pos_q    <= '0;
							step_q   <= TOP_STEP;
							up_q     <= 1'b0;
							state_q  <= S_FIND_RD;
						end
					end
				end
				S_FIND_RD, S_FIND_CMP: begin
					if (state_q == S_FIND_RD && !walk_over) begin
						nxt_q   <= walk_sum[PW-1:0];
						state_q <= S_FIND_CMP;
					end else begin
						k_q    <= find_k;
						step_q <= step_q >> 1;
						if (step_q == PW'(1)) begin
							pos_q      <= find_pos + 1'b1;
							val_addr_q <= AW'(find_pos);
							state_q    <= S_ADD_RD;
						end else begin
							pos_q   <= find_pos;
							state_q <= S_FIND_RD;
						end
					end
				end
				S_ADD_RD: begin
					state_q <= S_ADD_WR;
				end
				S_ADD_WR: begin
					if (walk_over) begin
						state_q <= S_DONE;
						if (up_q) begin
							loaded_q    <= loaded_q + 1'b1;
							remaining_q <= remaining_q + 1'b1;
						end else begin
							remaining_q <= remaining_q - 1'b1;
						end
					end else begin
						pos_q   <= walk_sum[PW-1:0];
						state_q <= S_ADD_RD;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q             <= 1'b1;
						out_q.removed_value     <= (status_q == ST_REMOVED) ?
							$signed(vs_rdata) : 32'sd0;
						out_q.status            <= status_q;
						out_q.remaining         <= 11'(remaining_q);
						state_q                 <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_remaining_le_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		remaining_q <= loaded_q)
		else $error("remaining count exceeds fill count");

	a_loaded_le_cap: assert property (@(posedge clk) disable iff (!arst_n)
		loaded_q <= CAP_P)
		else $error("fill count exceeds capacity");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.status == ST_CLEARED) |-> (out_q.remaining == '0))
		else $error("clear result reports entries left");

	a_tree_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		tr_we |-> (pos_q != '0 && pos_q <= CAP_P))
		else $error("tree write outside positions");
`endif

endmodule
`default_nettype wire
